// ===== src/bnht_pkg.sv =====
// Package for the bank number hash table.
// Holds the sizes, status codes and the item and slot types used by the RTL and testbench files.
// No dependencies.
package bnht_pkg;

	localparam int unsigned DEPTH = 64;
	localparam int unsigned ADDR_W = $clog2(DEPTH);
	localparam int unsigned KEY_W = 14;
	localparam int unsigned COUNT_W = 7;
	localparam int unsigned LOG2_W = 3;

	localparam logic [LOG2_W-1:0] LOG2_RESET = LOG2_W'(6);
	localparam logic [LOG2_W-1:0] LOG2_MAX = LOG2_W'(ADDR_W);
	localparam logic [6:0] PERC_LSB = 7'd127;
	localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(127);

	localparam logic CMD_FIND = 1'b0;
	localparam logic CMD_INSERT = 1'b1;

	localparam logic [1:0] ST_FOUND = 2'd0;
	localparam logic [1:0] ST_INSERTED = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] slot_index;
		logic is_percussion;
	} result_t;

	typedef struct packed {
		logic valid;
		logic [KEY_W-1:0] key;
	} slot_t;

	typedef struct packed {
		logic en;
		logic [ADDR_W-1:0] addr;
		logic [KEY_W-1:0] key;
	} slot_wr_t;

endpackage

// ===== src/bnht_in_if.sv =====
// Input channel of the bank number hash table: valid/ready plus a lookup command.
// No dependencies.
interface bnht_in_if;
	logic valid;
	logic ready;
	logic command;
	logic [6:0] bank_msb;
	logic [6:0] bank_lsb;

	modport source (output valid, output command, output bank_msb, output bank_lsb,
		input ready);
	modport sink (input valid, input command, input bank_msb, input bank_lsb,
		output ready);
endinterface

// ===== src/bnht_out_if.sv =====
// Output channel of the bank number hash table: valid/ready plus one lookup result.
// No dependencies.
interface bnht_out_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [5:0] slot_index;
	logic is_percussion;

	modport source (output valid, output status, output slot_index, output is_percussion,
		input ready);
	modport sink (input valid, input status, input slot_index, input is_percussion,
		output ready);
endinterface

// ===== src/bnht_slot_store.sv =====
// Slot store: key memory with registered read, plus per-slot valid flags.
// Depends on bnht_pkg.
module bnht_slot_store (
	input  logic clk,
	input  logic arst_n,
	input  logic rd_en,
	input  logic [bnht_pkg::ADDR_W-1:0] rd_addr,
	output bnht_pkg::slot_t rd_data,
	input  bnht_pkg::slot_wr_t wr
);

	logic [bnht_pkg::KEY_W-1:0] key_mem_q [bnht_pkg::DEPTH];
	logic [bnht_pkg::DEPTH-1:0] valid_q;
	logic [bnht_pkg::KEY_W-1:0] rd_key_q;
	logic rd_valid_q;

	// Write and read the key memory
	always_ff @(posedge clk) begin
		if (wr.en) begin
			key_mem_q[wr.addr] <= wr.key;
		end
		if (rd_en) begin
			rd_key_q <= key_mem_q[rd_addr];
		end
	end

	// Hold the valid flags; reset empties every slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data.valid = rd_valid_q;
	assign rd_data.key = rd_key_q;

endmodule

// ===== src/bank_number_hash_table.sv =====
// Bank number hash table: an open-addressed table of 14-bit MIDI bank keys (msb, lsb),
// home slot ((msb << 7) + lsb) masked to the slots in use, linear probing with wraparound.
// One item is worked on at a time. P slots are probed per item, where P runs from 1 up to
// the table size; each probe is one read of the slot memory followed by one compare. The
// next item is accepted while a finished result still waits on the output register. All
// slots are empty straight after reset: no clearing pass is needed. table_size_log2 above
// 6 is treated as 6; a size change leaves entries where they are.
// Depends on bnht_pkg, bnht_in_if, bnht_out_if and bnht_slot_store.
module bank_number_hash_table (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [bnht_pkg::LOG2_W-1:0] cfg_wdata,
	bnht_in_if.sink req,
	bnht_out_if.source rsp
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_CHECK = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0] state_q;
	logic [bnht_pkg::LOG2_W-1:0] size_log2_q;
	logic [bnht_pkg::LOG2_W-1:0] log2_used;
	logic [bnht_pkg::ADDR_W-1:0] mask;
	logic [bnht_pkg::ADDR_W-1:0] mask_q;
	logic [bnht_pkg::ADDR_W-1:0] start_q;
	logic [bnht_pkg::ADDR_W-1:0] pos_q;
	logic [bnht_pkg::ADDR_W-1:0] pos_next;
	logic [bnht_pkg::KEY_W-1:0] in_key;
	logic [bnht_pkg::ADDR_W-1:0] home;
	logic insert_q;
	logic [bnht_pkg::KEY_W-1:0] key_q;
	logic [bnht_pkg::COUNT_W-1:0] entry_count_q;
	bnht_pkg::result_t res_q;
	bnht_pkg::result_t out_q;
	logic out_valid_q;
	bnht_pkg::slot_t rd_data;
	bnht_pkg::slot_wr_t wr;
	logic in_acc;
	logic hit;
	logic empty;
	logic out_free;

	// Size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_log2_q <= bnht_pkg::LOG2_RESET;
		end else if (cfg_we) begin
			size_log2_q <= cfg_wdata;
		end
	end

	// Clamp the size to the built depth and form the slot mask
	assign log2_used = (size_log2_q > bnht_pkg::LOG2_MAX) ? bnht_pkg::LOG2_MAX : size_log2_q;
	assign mask = bnht_pkg::ADDR_W'(((bnht_pkg::ADDR_W+1)'(1) << log2_used)
		- (bnht_pkg::ADDR_W+1)'(1));

	// Home slot: the low bits of the full key, masked to the slots in use
	assign in_key = {req.bank_msb, req.bank_lsb};
	assign home = in_key[bnht_pkg::ADDR_W-1:0] & mask;

	assign in_acc = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || rsp.ready;

	// Probe decode on the slot read back from memory
	assign hit = rd_data.valid && (rd_data.key == key_q);
	assign empty = !rd_data.valid;
	assign pos_next = (pos_q + bnht_pkg::ADDR_W'(1)) & mask_q;

	// Store the key into the first empty slot on an insert
	assign wr.en = (state_q == S_CHECK) && empty && (insert_q == bnht_pkg::CMD_INSERT);
	assign wr.addr = pos_q;
	assign wr.key = key_q;

	bnht_slot_store u_store (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(state_q == S_READ),
		.rd_addr(pos_q),
		.rd_data(rd_data),
		.wr(wr)
	);

	// Item payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			insert_q <= req.command;
			key_q <= in_key;
			mask_q <= mask;
			start_q <= home;
			res_q.is_percussion <= (req.bank_lsb == bnht_pkg::PERC_LSB);
		end
		if (state_q == S_CHECK) begin
			if (hit) begin
				res_q.status <= bnht_pkg::ST_FOUND;
				res_q.slot_index <= pos_q;
			end else if (empty) begin
				res_q.status <= (insert_q == bnht_pkg::CMD_INSERT) ? bnht_pkg::ST_INSERTED
					: bnht_pkg::ST_NOT_FOUND;
				res_q.slot_index <= (insert_q == bnht_pkg::CMD_INSERT) ? pos_q : '0;
			end else begin
				res_q.status <= (insert_q == bnht_pkg::CMD_INSERT) ? bnht_pkg::ST_FULL
					: bnht_pkg::ST_NOT_FOUND;
				res_q.slot_index <= '0;
			end
		end
		if ((state_q == S_DONE) && out_free) begin
			out_q <= res_q;
		end
	end

	// Probe sequencer: read a slot, check it, advance or finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pos_q <= '0;
			entry_count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						pos_q <= home;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (hit || empty || (pos_next == start_q)) begin
						state_q <= S_DONE;
					end else begin
						pos_q <= pos_next;
						state_q <= S_READ;
					end
					if (wr.en && (entry_count_q != bnht_pkg::COUNT_MAX)) begin
						entry_count_q <= entry_count_q + bnht_pkg::COUNT_W'(1);
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.status = out_q.status;
	assign rsp.slot_index = out_q.slot_index;
	assign rsp.is_percussion = out_q.is_percussion;

endmodule

// ===== src/bnht_checker.sv =====
// Port-level checks for the bank number hash table, bound to the top level.
// Depends on bnht_pkg and bank_number_hash_table.
module bnht_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] status,
	input logic [5:0] slot_index,
	input logic is_percussion
);

	// One item at a time: no second item straight after an accepted one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("item accepted while another is in flight");

	// A result never appears in the cycle after acceptance: a probe needs a memory read
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !$rose(out_valid))
		else $error("result offered too early");

	// A miss or a full table reports slot zero
	a_miss_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ((status == bnht_pkg::ST_NOT_FOUND) || (status == bnht_pkg::ST_FULL)))
		|-> (slot_index == 6'd0))
		else $error("miss reports a nonzero slot");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(slot_index)
		&& $stable(is_percussion)))
		else $error("stalled result changed");

endmodule

bind bank_number_hash_table bnht_checker u_bnht_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(req.valid),
	.in_ready(req.ready),
	.out_valid(rsp.valid),
	.out_ready(rsp.ready),
	.status(rsp.status),
	.slot_index(rsp.slot_index),
	.is_percussion(rsp.is_percussion)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench for bank_number_hash_table: directed table then random lookups across table sizes.
// Each result is checked against its typed expectation or else a behavioural copy of the probing table.
// Depends on bnht_pkg, bnht_in_if, bnht_out_if and the bank_number_hash_table RTL.
module tb;

	localparam int unsigned CYCLE_LIMIT = 1_200_000;
	localparam int unsigned DRAIN_CYCLES = 2 + 2 * bnht_pkg::DEPTH + 8;
	localparam int unsigned RANDOM_PER_SIZE = 225;

	typedef struct {
		bit is_cfg;
		logic [bnht_pkg::LOG2_W-1:0] size_log2;
		logic cmd;
		logic [6:0] msb;
		logic [6:0] lsb;
		bit typed;
		bnht_pkg::result_t res;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [bnht_pkg::LOG2_W-1:0] cfg_wdata = '0;

	bnht_in_if req_if ();
	bnht_out_if rsp_if ();

	bank_number_hash_table u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req_if),
		.rsp(rsp_if)
	);

	// Shadow copy of the table, its size register and the insert count
	bnht_pkg::slot_t shadow_slots [bnht_pkg::DEPTH];
	logic [bnht_pkg::LOG2_W-1:0] shadow_log2 = bnht_pkg::LOG2_RESET;
	logic [bnht_pkg::COUNT_W-1:0] shadow_count = '0;

	bnht_pkg::result_t pending_results [$];
	plan_row_t plan [$];
	logic [13:0] key_pool [$];

	// Typed expectation travelling alongside the item, updated with the payload
	logic fixed_valid = 1'b0;
	bnht_pkg::result_t fixed_res = '0;

	int unsigned cycle_count = 0;
	int unsigned error_count = 0;
	int unsigned item_count = 0;
	int unsigned size_count = 0;
	int unsigned stat_hits [4] = '{0, 0, 0, 0};
	int unsigned stall_left = 0;
	bit sink_calm = 1'b0;
	bit src_calm = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		for (int i = 0; i < bnht_pkg::DEPTH; i++)
			shadow_slots[i] = '0;
	end

	// Mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Probe the shadow table as the block does; insert on the first empty slot
	function automatic bnht_pkg::result_t lookup_bank(logic cmd, logic [6:0] msb,
		logic [6:0] lsb);
		logic [bnht_pkg::KEY_W-1:0] key;
		int unsigned used;
		int unsigned pos;
		int unsigned n;
		bnht_pkg::result_t r;
		key = {msb, lsb};
		used = 1 << shadow_log2;
		while (used > bnht_pkg::DEPTH && used > 1)
			used = used >> 1;
		pos = key & (used - 1);
		r.status = (cmd == bnht_pkg::CMD_INSERT) ? bnht_pkg::ST_FULL : bnht_pkg::ST_NOT_FOUND;
		r.slot_index = '0;
		r.is_percussion = (lsb == bnht_pkg::PERC_LSB);
		for (n = 0; n < used; n++) begin
			if (shadow_slots[pos].valid && shadow_slots[pos].key == key) begin
				r.status = bnht_pkg::ST_FOUND;
				r.slot_index = 6'(pos);
				break;
			end
			if (!shadow_slots[pos].valid) begin
				if (cmd == bnht_pkg::CMD_INSERT) begin
					shadow_slots[pos].valid = 1'b1;
					shadow_slots[pos].key = key;
					if (shadow_count != bnht_pkg::COUNT_MAX)
						shadow_count = shadow_count + 1'b1;
					r.status = bnht_pkg::ST_INSERTED;
					r.slot_index = 6'(pos);
				end
				break;
			end
			pos = (pos + 1) & (used - 1);
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		$display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
		error_count++;
	endtask

	// Track config writes and accepted items; queue what each item should return
	always @(posedge clk) begin : track_inputs
		bnht_pkg::result_t predicted;
		if (cfg_we)
			shadow_log2 = cfg_wdata;
		if (req_if.valid && req_if.ready) begin
			predicted = lookup_bank(req_if.command, req_if.bank_msb, req_if.bank_lsb);
			pending_results.push_back(fixed_valid ? fixed_res : predicted);
			item_count++;
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin : check_results
		bnht_pkg::result_t want;
		if (rsp_if.valid && rsp_if.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("results outstanding", 1, 0);
			end else begin
				want = pending_results.pop_front();
				stat_hits[want.status]++;
				if (rsp_if.status !== want.status)
					report_mismatch("status", rsp_if.status, want.status);
				if (rsp_if.slot_index !== want.slot_index)
					report_mismatch("slot_index", rsp_if.slot_index, want.slot_index);
				if (rsp_if.is_percussion !== want.is_percussion)
					report_mismatch("is_percussion", rsp_if.is_percussion, want.is_percussion);
			end
		end
	end

	// Pace the result side: random stalls, with calm stretches
	always @(posedge clk) begin : sink_pacing
		int unsigned g;
		if (cycle_count % 300 == 0)
			sink_calm <= ($urandom_range(0, 3) == 0);
		if (stall_left != 0) begin
			rsp_if.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (sink_calm) begin
			rsp_if.ready <= 1'b1;
		end else begin
			g = pick_gap();
			rsp_if.ready <= (g == 0);
			stall_left <= (g == 0) ? 0 : g - 1;
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Offer one item after a random gap and hold it until accepted
	task automatic send_lookup(input logic cmd, input logic [6:0] msb, input logic [6:0] lsb,
		input bit typed, input bnht_pkg::result_t res);
		int unsigned gap;
		gap = src_calm ? 0 : pick_gap();
		if (gap != 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.command <= cmd;
		req_if.bank_msb <= msb;
		req_if.bank_lsb <= lsb;
		fixed_valid <= typed;
		fixed_res <= res;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
	endtask

	// Drain the block, then write the size register
	task automatic set_table_size(input logic [bnht_pkg::LOG2_W-1:0] size_log2);
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= size_log2;
		@(posedge clk);
		cfg_we <= 1'b0;
		size_count++;
	endtask

	task automatic add_row(input bit is_cfg, input logic [bnht_pkg::LOG2_W-1:0] size_log2,
		input logic cmd, input logic [6:0] msb, input logic [6:0] lsb, input bit typed,
		input logic [1:0] status, input logic [5:0] slot, input logic perc);
		plan_row_t row;
		row.is_cfg = is_cfg;
		row.size_log2 = size_log2;
		row.cmd = cmd;
		row.msb = msb;
		row.lsb = lsb;
		row.typed = typed;
		row.res.status = status;
		row.res.slot_index = slot;
		row.res.is_percussion = perc;
		plan.push_back(row);
	endtask

	initial begin : stimulus
		logic [bnht_pkg::LOG2_W-1:0] sizes [8];
		logic [13:0] key;
		logic cmd;
		int unsigned r;

		req_if.valid = 1'b0;
		req_if.command = bnht_pkg::CMD_FIND;
		req_if.bank_msb = '0;
		req_if.bank_lsb = '0;
		rsp_if.ready = 1'b0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table at full size, extremes of the key, collisions and wraparound
		add_row(0, 0, bnht_pkg::CMD_FIND, 7'd0, 7'd0, 1, bnht_pkg::ST_NOT_FOUND, 6'd0, 1'b0);
		add_row(0, 0, bnht_pkg::CMD_FIND, 7'd127, 7'd127, 1, bnht_pkg::ST_NOT_FOUND, 6'd0,
			1'b1);
		add_row(0, 0, bnht_pkg::CMD_INSERT, 7'd0, 7'd0, 1, bnht_pkg::ST_INSERTED, 6'd0, 1'b0);
		add_row(0, 0, bnht_pkg::CMD_FIND, 7'd0, 7'd0, 1, bnht_pkg::ST_FOUND, 6'd0, 1'b0);
		add_row(0, 0, bnht_pkg::CMD_INSERT, 7'd127, 7'd127, 1, bnht_pkg::ST_INSERTED, 6'd63,
			1'b1);
		add_row(0, 0, bnht_pkg::CMD_INSERT, 7'd0, 7'd64, 0, 0, 0, 0);
		add_row(0, 0, bnht_pkg::CMD_INSERT, 7'd1, 7'd63, 0, 0, 0, 0);
		add_row(0, 0, bnht_pkg::CMD_FIND, 7'd0, 7'd64, 0, 0, 0, 0);
		add_row(0, 0, bnht_pkg::CMD_FIND, 7'd127, 7'd127, 1, bnht_pkg::ST_FOUND, 6'd63, 1'b1);
		add_row(0, 0, bnht_pkg::CMD_INSERT, 7'd0, 7'd0, 1, bnht_pkg::ST_FOUND, 6'd0, 1'b0);
		// One slot in use: full table and a find that wraps
		add_row(1, 3'd0, 0, 0, 0, 0, 0, 0, 0);
		add_row(0, 0, bnht_pkg::CMD_FIND, 7'd0, 7'd0, 1, bnht_pkg::ST_FOUND, 6'd0, 1'b0);
		add_row(0, 0, bnht_pkg::CMD_INSERT, 7'd5, 7'd5, 1, bnht_pkg::ST_FULL, 6'd0, 1'b0);
		add_row(0, 0, bnht_pkg::CMD_FIND, 7'd5, 7'd5, 1, bnht_pkg::ST_NOT_FOUND, 6'd0, 1'b0);
		add_row(0, 0, bnht_pkg::CMD_INSERT, 7'd3, 7'd127, 1, bnht_pkg::ST_FULL, 6'd0, 1'b1);
		// Size above the built depth falls back to the full table
		add_row(1, 3'd7, 0, 0, 0, 0, 0, 0, 0);
		add_row(0, 0, bnht_pkg::CMD_FIND, 7'd1, 7'd63, 0, 0, 0, 0);
		add_row(0, 0, bnht_pkg::CMD_INSERT, 7'd127, 7'd126, 0, 0, 0, 0);
		add_row(0, 0, bnht_pkg::CMD_FIND, 7'd85, 7'd42, 0, 0, 0, 0);
		add_row(0, 0, bnht_pkg::CMD_INSERT, 7'd42, 7'd85, 0, 0, 0, 0);
		// Two slots in use, both taken; entries above the size are kept
		add_row(1, 3'd1, 0, 0, 0, 0, 0, 0, 0);
		add_row(0, 0, bnht_pkg::CMD_INSERT, 7'd3, 7'd3, 1, bnht_pkg::ST_FULL, 6'd0, 1'b0);
		add_row(0, 0, bnht_pkg::CMD_FIND, 7'd0, 7'd64, 0, 0, 0, 0);
		add_row(1, 3'd6, 0, 0, 0, 0, 0, 0, 0);
		add_row(0, 0, bnht_pkg::CMD_FIND, 7'd127, 7'd126, 0, 0, 0, 0);

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				set_table_size(plan[i].size_log2);
			else
				send_lookup(plan[i].cmd, plan[i].msb, plan[i].lsb, plan[i].typed, plan[i].res);
		end

		// Random lookups, one phase per table size; reuse keys so finds hit
		sizes = '{3'd0, 3'd4, 3'd1, 3'd7, 3'd2, 3'd5, 3'd3, 3'd6};
		foreach (sizes[p]) begin
			set_table_size(sizes[p]);
			key_pool.delete();
			for (int n = 0; n < RANDOM_PER_SIZE; n++) begin
				if (n % 64 == 0)
					src_calm = ($urandom_range(0, 3) == 0);
				r = $urandom_range(0, 99);
				if (key_pool.size() != 0 && r < 55) begin
					key = key_pool[$urandom_range(0, key_pool.size() - 1)];
				end else begin
					key = 14'($urandom);
					if (r >= 94)
						key[6:0] = bnht_pkg::PERC_LSB;
					else if (r >= 90)
						key[13:7] = (r[0]) ? 7'd127 : 7'd0;
					if (key_pool.size() < 32)
						key_pool.push_back(key);
				end
				cmd = ($urandom_range(0, 9) < 6) ? bnht_pkg::CMD_INSERT : bnht_pkg::CMD_FIND;
				send_lookup(cmd, key[13:7], key[6:0], 1'b0, '0);
			end
		end

		// Drain and give the block time to show any stray result
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d lookups over %0d size settings (extremes 0, 6 and 7 included).",
			item_count, size_count);
		$display("Results: %0d found, %0d inserted, %0d not found, %0d table full.",
			stat_hits[bnht_pkg::ST_FOUND], stat_hits[bnht_pkg::ST_INSERTED],
			stat_hits[bnht_pkg::ST_NOT_FOUND], stat_hits[bnht_pkg::ST_FULL]);
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", error_count);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
